// File: hw/rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned FAULT_W = 16;
  localparam int unsigned CFG_W   = 4;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = 4'd3;
  localparam logic [FAULT_W-1:0] FAULT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              start_run;
  } in_item_t;

  typedef struct packed {
    logic               fault;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrupr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lrupr_pkg::dp_stat_t  stat_i,
  output lrupr_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  assign in_ready_o = in_ready_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_valid_i && in_ready_q;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.update = (state_q == ST_UPDATE) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= ST_SCAN;
            in_ready_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_last) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // hold until the output register can take the result
          if (stat_i.out_free) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrupr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_dp #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lrupr_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire lrupr_pkg::in_item_t                  in_item_i,
  input  wire lrupr_pkg::ctrl_cmd_t                 cmd_i,
  output lrupr_pkg::dp_stat_t                       stat_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output lrupr_pkg::out_item_t                      out_item_o
);

  localparam int unsigned SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [lrupr_pkg::CFG_W-1:0]   frame_count_q;

  logic [lrupr_pkg::PAGE_W-1:0]  frame_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         frame_valid_q;
  logic [SW-1:0]                 rank_q       [MAX_FRAMES];
  logic [lrupr_pkg::FAULT_W-1:0] fault_cnt_q;

  // item being worked on and scan results
  logic [lrupr_pkg::PAGE_W-1:0]  page_q;
  logic [SW-1:0]                 idx_q;
  logic                          hit_q;
  logic [SW-1:0]                 hit_slot_q;
  logic [SW-1:0]                 hit_rank_q;
  logic                          free_q;
  logic [SW-1:0]                 free_slot_q;
  logic [SW-1:0]                 best_slot_q;
  logic [SW-1:0]                 best_rank_q;
  logic [lrupr_pkg::PAGE_W-1:0]  best_page_q;

  logic                          out_valid_q;
  lrupr_pkg::out_item_t          out_item_q;

  logic [SW-1:0]                 lim_m1;
  logic [31:0]                   fc_ext;
  logic                          scan_hit;
  logic [SW-1:0]                 upd_slot;
  logic [SW-1:0]                 upd_rank;
  logic                          upd_age_all;
  logic                          upd_fault;
  logic [lrupr_pkg::FAULT_W-1:0] fault_next;

  // effective frame limit minus one: zero acts as one, too large acts as capacity
  always_comb begin
    fc_ext = 32'(frame_count_q);
    if (fc_ext == 32'd0) begin
      lim_m1 = '0;
    end else if (fc_ext > MAX_FRAMES) begin
      lim_m1 = SW'(MAX_FRAMES - 1);
    end else begin
      lim_m1 = SW'(fc_ext - 32'd1);
    end
  end

  assign scan_hit = frame_valid_q[idx_q] && (frame_page_q[idx_q] == page_q) && !hit_q;

  always_comb begin
    upd_fault = !hit_q;
    if (hit_q) begin
      upd_slot    = hit_slot_q;
      upd_rank    = hit_rank_q;
      upd_age_all = 1'b0;
    end else if (free_q) begin
      upd_slot    = free_slot_q;
      upd_rank    = '0;
      upd_age_all = 1'b1;
    end else begin
      upd_slot    = best_slot_q;
      upd_rank    = best_rank_q;
      upd_age_all = 1'b0;
    end
    if (upd_fault && (fault_cnt_q != lrupr_pkg::FAULT_MAX)) begin
      fault_next = fault_cnt_q + 1'b1;
    end else begin
      fault_next = fault_cnt_q;
    end
  end

  assign stat_o.scan_last = (idx_q == lim_m1);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= lrupr_pkg::FRAME_COUNT_RESET;
      frame_valid_q <= '0;
      fault_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < MAX_FRAMES; k++) begin
        rank_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load && in_item_i.start_run) begin
        frame_valid_q <= '0;
        fault_cnt_q   <= '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
          rank_q[k] <= '0;
        end
      end
      if (cmd_i.update) begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
          if (SW'(k) == upd_slot) begin
            rank_q[k] <= '0;
          end else if (frame_valid_q[k] && (upd_age_all || (rank_q[k] < upd_rank))) begin
            rank_q[k] <= rank_q[k] + 1'b1;
          end
        end
        frame_valid_q[upd_slot] <= 1'b1;
        fault_cnt_q             <= fault_next;
        out_valid_q             <= 1'b1;
      end
    end
  end

  // payload, scan, frame page and output item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= in_item_i.page;
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (scan_hit) begin
        hit_q      <= 1'b1;
        hit_slot_q <= idx_q;
        hit_rank_q <= rank_q[idx_q];
      end
      // the highest free slot wins
      if (!frame_valid_q[idx_q]) begin
        free_q      <= 1'b1;
        free_slot_q <= idx_q;
      end
      if ((idx_q == '0) || (rank_q[idx_q] > best_rank_q)) begin
        best_slot_q <= idx_q;
        best_rank_q <= rank_q[idx_q];
        best_page_q <= frame_page_q[idx_q];
      end
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.update) begin
      if (upd_fault) begin
        frame_page_q[upd_slot] <= page_q;
      end
      out_item_q.fault         <= upd_fault;
      out_item_q.slot          <= lrupr_pkg::SLOT_W'(32'(upd_slot));
      out_item_q.evicted_valid <= upd_fault && !free_q;
      out_item_q.evicted_page  <= (upd_fault && !free_q) ? best_page_q : '0;
      out_item_q.fault_total   <= fault_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake                  | payload
// --------+----------------------------+---------------------------------------
// cfg     | cfg_we_i                   | cfg_wdata_i (frame_count)
// in      | in_valid_i / in_ready_o    | in_item_i (page, start_run)
// out     | out_valid_o / out_ready_i  | out_item_o (fault, slot, evicted, total)
//
// each item is accepted, then scanned over its limit active frames, limit being the
// clamped frame count, then updated; the update waits while the output register is full
// the frame scan walks the slots one per cycle through a single comparator and rank
// compare; reset leaves all frames empty and frame_count at 3
// a finished result sits in the output register, the next item is taken while it waits

module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lrupr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire lrupr_pkg::in_item_t         in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output lrupr_pkg::out_item_t             out_item_o
);

  lrupr_pkg::ctrl_cmd_t cmd;
  lrupr_pkg::dp_stat_t  stat;

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrupr_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAMES    = 8;
  localparam int unsigned RUN_LIMIT = 300000;
  localparam int unsigned SETTLE    = 16;
  localparam int unsigned PHASES    = 14;
  localparam logic [lrupr_pkg::CFG_W-1:0] PHASE_FRAMES [PHASES] = '{
    4'd3, 4'd8, 4'd1, 4'd0, 4'd5, 4'd15, 4'd2, 4'd7, 4'd9, 4'd4, 4'd6, 4'd10, 4'd8, 4'd12
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  lrupr_pkg::in_item_t         in_item_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  lrupr_pkg::out_item_t        out_item_o;

  lru_page_replacement #(
    .MAX_FRAMES(FRAMES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // shadow copy of the frame table
  logic [lrupr_pkg::PAGE_W-1:0]  frame_pg    [FRAMES];
  logic                          frame_used  [FRAMES];
  logic [2:0]                    frame_age   [FRAMES];
  logic [lrupr_pkg::FAULT_W-1:0] fault_cnt;
  logic [lrupr_pkg::CFG_W-1:0]   frames_cfg;

  lrupr_pkg::out_item_t pending_results[$];
  lrupr_pkg::out_item_t want;
  int          errors = 0;
  int          refs_sent = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          faults_seen = 0;
  int          evictions_seen = 0;
  int unsigned cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_cycles = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void clear_frames();
    for (int unsigned k = 0; k < FRAMES; k++) begin
      frame_pg[k]   = '0;
      frame_used[k] = 1'b0;
      frame_age[k]  = '0;
    end
    fault_cnt = '0;
  endfunction

  // slot sel becomes most recent, used frames younger than bound get one older
  function automatic void age_frames(input int unsigned sel, input int unsigned bound);
    for (int unsigned k = 0; k < FRAMES; k++) begin
      if (k != sel && frame_used[k] && frame_age[k] < bound) begin
        frame_age[k] = frame_age[k] + 3'd1;
      end
    end
    frame_age[sel] = '0;
  endfunction

  function automatic lrupr_pkg::out_item_t lru_predict(input lrupr_pkg::in_item_t it);
    lrupr_pkg::out_item_t r;
    int unsigned limit;
    int unsigned sel;
    int unsigned free_slot;
    int unsigned best_rank;
    logic        hit;
    logic        have_free;
    r = '0;
    if (it.start_run) begin
      clear_frames();
    end
    limit = 32'(frames_cfg);
    if (limit < 1) limit = 1;
    if (limit > FRAMES) limit = FRAMES;
    hit = 1'b0;
    have_free = 1'b0;
    sel = 0;
    free_slot = 0;
    for (int unsigned k = 0; k < limit; k++) begin
      if (frame_used[k] && frame_pg[k] == it.page && !hit) begin
        hit = 1'b1;
        sel = k;
      end
      if (!frame_used[k]) begin
        have_free = 1'b1;
        free_slot = k;
      end
    end
    if (hit) begin
      age_frames(sel, 32'(frame_age[sel]));
    end else begin
      if (have_free) begin
        sel = free_slot;
        age_frames(sel, FRAMES);
        frame_used[sel] = 1'b1;
      end else begin
        sel = 0;
        best_rank = 0;
        for (int unsigned k = 0; k < limit; k++) begin
          if (k == 0 || 32'(frame_age[k]) > best_rank) begin
            sel = k;
            best_rank = 32'(frame_age[k]);
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_pg[sel];
        age_frames(sel, best_rank);
      end
      frame_pg[sel] = it.page;
      if (fault_cnt != lrupr_pkg::FAULT_MAX) fault_cnt = fault_cnt + 1'b1;
    end
    r.fault = !hit;
    r.slot = sel[lrupr_pkg::SLOT_W-1:0];
    r.fault_total = fault_cnt;
    return r;
  endfunction

  // one page reference, predicted at acceptance
  task automatic send_ref(input logic [lrupr_pkg::PAGE_W-1:0] page, input logic start);
    int                   gap;
    lrupr_pkg::in_item_t  it;
    lrupr_pkg::out_item_t exp_item;
    it.page = page;
    it.start_run = start;
    gap = tx_idle_on ? int'($urandom_range(0, 13)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    exp_item = lru_predict(it);
    pending_results.insert(pending_results.size(), exp_item);
    refs_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_frame_count(input logic [lrupr_pkg::CFG_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    frames_cfg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // reset value of three frames, page 0 on empty frames, repeats while filling
  task automatic test_after_reset();
    send_ref(8'd0, 1'b0);
    send_ref(8'd255, 1'b0);
    send_ref(8'd0, 1'b0);
    send_ref(8'd7, 1'b0);
    send_ref(8'd42, 1'b0);
    send_ref(8'd255, 1'b0);
    send_ref(8'd0, 1'b1);
    send_ref(8'd0, 1'b0);
  endtask

  // zero acts as one frame, values above capacity act as full capacity
  task automatic test_frame_limits();
    set_frame_count(4'd0);
    send_ref(8'd5, 1'b1);
    send_ref(8'd5, 1'b0);
    send_ref(8'd6, 1'b0);
    send_ref(8'd5, 1'b0);
    set_frame_count(4'd15);
    for (int i = 0; i < 9; i++) begin
      send_ref(8'h80 + 8'(i * 8'h11), i == 0);
    end
    send_ref(8'h91, 1'b0);
  endtask

  // frames above a lowered limit are stale but keep aging
  task automatic test_limit_lowered();
    set_frame_count(4'd2);
    send_ref(8'h80, 1'b0);
    send_ref(8'h80, 1'b0);
    send_ref(8'h91, 1'b0);
    send_ref(8'hff, 1'b0);
    set_frame_count(4'd8);
    send_ref(8'h80, 1'b0);
    send_ref(8'ha2, 1'b0);
  endtask

  task automatic test_stall_and_pause();
    logic [lrupr_pkg::PAGE_W-1:0] pool [6];
    set_frame_count(4'd4);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int j = 0; j < 6; j++) pool[j] = 8'($urandom);
    rx_hold_cycles = 200;
    for (int i = 0; i < 30; i++) begin
      send_ref(pool[$urandom_range(0, 5)], i == 0);
    end
    // sender waits for every result before going on
    drain_results();
    for (int i = 0; i < 20; i++) begin
      send_ref(pool[$urandom_range(0, 5)], 1'b0);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // mostly a small working set so hits, fills and evictions mix
  task automatic test_random_mix();
    logic [lrupr_pkg::PAGE_W-1:0] pool [10];
    logic [lrupr_pkg::PAGE_W-1:0] pg;
    int                           span;
    int                           pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_frame_count(PHASE_FRAMES[ph]);
      tx_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
      rx_idle_on = (ph % 4 == 0) || (ph % 4 == 1);
      span = int'(PHASE_FRAMES[ph]);
      if (span < 1) span = 1;
      if (span > FRAMES) span = FRAMES;
      for (int j = 0; j < 10; j++) pool[j] = 8'($urandom);
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) pool[$urandom_range(0, 9)] = 8'($urandom);
        if (pick < 88) begin
          pg = pool[$urandom_range(0, span + 1)];
        end else begin
          pg = 8'($urandom);
        end
        send_ref(pg, $urandom_range(0, 99) < 3);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : receiver
    int gap;
    int hold;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      gap = rx_idle_on ? int'($urandom_range(0, 13)) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i === 1'b1));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (want.fault !== out_item_o.fault || want.slot !== out_item_o.slot ||
            want.evicted_valid !== out_item_o.evicted_valid ||
            want.evicted_page !== out_item_o.evicted_page ||
            want.fault_total !== out_item_o.fault_total) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d at cycle %0d", results_seen, cycles);
            $display("  exp fault=%b slot=%0d ev=%b ev_page=%0d total=%0d", want.fault,
                     want.slot, want.evicted_valid, want.evicted_page, want.fault_total);
            $display("  got fault=%b slot=%0d ev=%b ev_page=%0d total=%0d", out_item_o.fault,
                     out_item_o.slot, out_item_o.evicted_valid, out_item_o.evicted_page,
                     out_item_o.fault_total);
          end
        end
        if (want.fault) faults_seen++;
        else hits_seen++;
        if (want.evicted_valid) evictions_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    clear_frames();
    frames_cfg = lrupr_pkg::FRAME_COUNT_RESET;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_frame_limits();
    test_limit_lowered();
    test_stall_and_pause();
    test_random_mix();

    drain_results();
    errors += pending_results.size();
    $display("%0d references, %0d results: %0d hits, %0d faults, %0d evictions",
             refs_sent, results_seen, hits_seen, faults_seen, evictions_seen);
    $display("frame counts from 0 to 15, lowered limits, start flag, long stall, drain pause");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
